@@ design/uart_pkg.sv @@
// shared constants and types for the 8n1 uart transceiver
package uart_pkg;

    // data bits per frame
    localparam int DATA_BITS = 8;
    // shift register width: at least one byte
    localparam int SHIFT_W   = (DATA_BITS > 8) ? DATA_BITS : 8;
    localparam int CNT_W     = 4;
    localparam int TIMER_W   = 8;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BIT_PERIOD = 2'd0,
        REG_HALF_BIT   = 2'd1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        RX_OK          = 2'd0,
        RX_FALSE_START = 2'd1,
        RX_STOP_LOW    = 2'd2
    } rx_status_t;

    localparam logic [7:0]         BIT_PERIOD_RESET = 8'd25;
    localparam logic [7:0]         HALF_BIT_RESET   = 8'd10;
    localparam logic [7:0]         RX_ERROR_BYTE    = 8'hFF;

    typedef struct packed {
        logic [1:0] rx_status;
        logic [7:0] rx_byte;
        logic       rx_done;
        logic       tx_busy;
        logic       tx_line;
    } result_t;

endpackage

@@ design/uart_8n1_transceiver.sv @@
// 8n1 uart transmitter and receiver paced by a timer tick, one word per clock while the output is not stalled
// a result word is registered and shows on m_tdata in the cycle after its input word is accepted
// throughput: one input word per cycle while the output register is empty or being drained
// the tx and rx bit timers, counters and shifters advance only on an accepted word, at most once per word
// reset (rst_n low, asynchronous): both sides idle, tx line high, bit_period 25, half_bit 10
// the output register is empty after reset
module uart_8n1_transceiver
    import uart_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // tick[0], rx_line[1], tx_start[2], tx_byte[10:3], zeros above
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // tx_line[0], tx_busy[1], rx_done[2], rx_byte[10:3], rx_status[12:11], zeros above
    output logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [7:0]         bit_period_q_reg;
    logic [7:0]         half_bit_reg;

    logic [SHIFT_W-1:0] tx_shift_reg,     tx_shift_next;
    logic [CNT_W-1:0]   tx_bit_count_reg, tx_bit_count_next;
    logic [TIMER_W-1:0] tx_timer_reg,     tx_timer_next;
    logic               tx_active_reg,    tx_active_next;
    logic               tx_level_reg,     tx_level_next;
    logic [SHIFT_W-1:0] rx_shift_reg,     rx_shift_next;
    logic [CNT_W-1:0]   rx_bit_count_reg, rx_bit_count_next;
    logic [TIMER_W-1:0] rx_timer_reg,     rx_timer_next;
    logic               rx_active_reg,    rx_active_next;

    logic               out_valid_reg;
    result_t            out_reg, out_next;

    logic               in_tick, in_rx_line, in_tx_start;
    logic [7:0]         in_tx_byte;
    logic               accept;
    logic               tx_expired, rx_expired;
    logic [TIMER_W-1:0] rx_limit;
    logic               rx_done;
    logic [7:0]         rx_byte;
    logic [1:0]         rx_status;

    assign in_tick     = s_tdata[0];
    assign in_rx_line  = s_tdata[1];
    assign in_tx_start = s_tdata[2];
    assign in_tx_byte  = s_tdata[10:3];

    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'(out_reg);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_period_q_reg <= BIT_PERIOD_RESET;
            half_bit_reg     <= HALF_BIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_BIT_PERIOD: bit_period_q_reg <= cfg_data;
                REG_HALF_BIT:   half_bit_reg     <= cfg_data;
                default:        ;
            endcase
        end
    end

    // transmitter
    always_comb
    begin
        tx_shift_next     = tx_shift_reg;
        tx_bit_count_next = tx_bit_count_reg;
        tx_timer_next     = tx_timer_reg;
        tx_active_next    = tx_active_reg;
        tx_level_next     = tx_level_reg;
        tx_expired        = tx_timer_reg >= bit_period_q_reg;
        if (!tx_active_reg)
        begin
            if (in_tx_start)
            begin
                tx_shift_next     = SHIFT_W'(in_tx_byte);
                tx_bit_count_next = '0;
                tx_timer_next     = '0;
                tx_active_next    = 1'b1;
                tx_level_next     = 1'b0;
            end
        end
        else if (in_tick)
        begin
            if (tx_expired)
            begin
                tx_timer_next     = '0;
                tx_bit_count_next = tx_bit_count_reg + CNT_W'(1);
                if (tx_bit_count_next >= CNT_W'(1) && tx_bit_count_next <= CNT_W'(DATA_BITS))
                begin
                    tx_level_next = tx_shift_reg[0];
                    tx_shift_next = tx_shift_reg >> 1;
                end
                else if (tx_bit_count_next == CNT_W'(DATA_BITS + 1))
                    tx_level_next = 1'b1;
                else
                begin
                    tx_level_next  = 1'b1;
                    tx_active_next = 1'b0;
                end
            end
            else
                tx_timer_next = tx_timer_reg + TIMER_W'(1);
        end
    end

    // receiver
    always_comb
    begin
        rx_shift_next     = rx_shift_reg;
        rx_bit_count_next = rx_bit_count_reg;
        rx_timer_next     = rx_timer_reg;
        rx_active_next    = rx_active_reg;
        rx_done           = 1'b0;
        rx_byte           = '0;
        rx_status         = RX_OK;
        // start bit is rechecked after half_bit, later bits after bit_period
        rx_limit          = (rx_bit_count_reg == '0) ? half_bit_reg : bit_period_q_reg;
        rx_expired        = rx_timer_reg >= rx_limit;
        if (!rx_active_reg)
        begin
            if (!in_rx_line)
            begin
                rx_active_next    = 1'b1;
                rx_bit_count_next = '0;
                rx_timer_next     = '0;
                rx_shift_next     = '0;
            end
        end
        else if (in_tick)
        begin
            if (rx_expired)
            begin
                rx_timer_next = '0;
                if (rx_bit_count_reg == '0)
                begin
                    if (in_rx_line)
                    begin
                        rx_done        = 1'b1;
                        rx_byte        = RX_ERROR_BYTE;
                        rx_status      = RX_FALSE_START;
                        rx_active_next = 1'b0;
                    end
                    else
                        rx_bit_count_next = CNT_W'(1);
                end
                else if (rx_bit_count_reg <= CNT_W'(DATA_BITS))
                begin
                    for (int i = 0; i < DATA_BITS; i++)
                    begin
                        if (in_rx_line && rx_bit_count_reg == CNT_W'(i + 1))
                            rx_shift_next[i] = 1'b1;
                    end
                    rx_bit_count_next = rx_bit_count_reg + CNT_W'(1);
                end
                else
                begin
                    rx_done = 1'b1;
                    if (in_rx_line)
                    begin
                        rx_byte   = rx_shift_reg[7:0];
                        rx_status = RX_OK;
                    end
                    else
                    begin
                        rx_byte   = RX_ERROR_BYTE;
                        rx_status = RX_STOP_LOW;
                    end
                    rx_active_next = 1'b0;
                end
            end
            else
                rx_timer_next = rx_timer_reg + TIMER_W'(1);
        end
    end

    always_comb
    begin
        out_next.tx_line   = tx_level_next;
        out_next.tx_busy   = tx_active_next;
        out_next.rx_done   = rx_done;
        out_next.rx_byte   = rx_byte;
        out_next.rx_status = rx_status;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_shift_reg     <= '0;
            tx_bit_count_reg <= '0;
            tx_timer_reg     <= '0;
            tx_active_reg    <= 1'b0;
            tx_level_reg     <= 1'b1;
            rx_shift_reg     <= '0;
            rx_bit_count_reg <= '0;
            rx_timer_reg     <= '0;
            rx_active_reg    <= 1'b0;
        end
        else if (accept)
        begin
            tx_shift_reg     <= tx_shift_next;
            tx_bit_count_reg <= tx_bit_count_next;
            tx_timer_reg     <= tx_timer_next;
            tx_active_reg    <= tx_active_next;
            tx_level_reg     <= tx_level_next;
            rx_shift_reg     <= rx_shift_next;
            rx_bit_count_reg <= rx_bit_count_next;
            rx_timer_reg     <= rx_timer_next;
            rx_active_reg    <= rx_active_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    // result word, held while the sink stalls
    always_ff @(posedge clk)
    begin
        if (accept)
            out_reg <= out_next;
    end

endmodule

@@ design/uart_checker.sv @@
// port-level checks for the uart transceiver and their bind
module uart_checker
    import uart_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata
);

    // a stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // no reception ended: byte and status read zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[2] |-> m_tdata[12:3] == 10'd0)
        else $error("rx byte or status set without rx_done");

    // an error status always carries the error byte
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[2] && m_tdata[12:11] != RX_OK
        |-> m_tdata[10:3] == RX_ERROR_BYTE
            && (m_tdata[12:11] == RX_FALSE_START || m_tdata[12:11] == RX_STOP_LOW))
        else $error("bad rx error report");

    // idle transmitter leaves the line high
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[1] |-> m_tdata[0])
        else $error("tx line low while transmitter idle");

endmodule

bind uart_8n1_transceiver uart_checker u_uart_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ sim/tb.sv @@
// self-checking testbench for the 8n1 uart transceiver: loopback, scripted frames and line noise
`timescale 1ns / 100ps

module tb;
    import uart_pkg::*;

    localparam int CYCLE_LIMIT    = 300000;
    localparam int RX_HOLD_CYCLES = 200;
    localparam int PHASE_WORDS    = 118;
    localparam int NUM_PHASES     = 12;

    typedef enum {LINE_LOOP, LINE_FRAMES, LINE_NOISE} line_mode_t;

    // tracks both halves of the link and holds the pin states each word should produce
    class uart_frame_tracker;
        logic [7:0]         bit_period;
        logic [7:0]         half_bit;
        logic [SHIFT_W-1:0] tx_shift;
        logic [CNT_W-1:0]   tx_count;
        logic [TIMER_W-1:0] tx_timer;
        logic               tx_active;
        logic               tx_level;
        logic [SHIFT_W-1:0] rx_shift;
        logic [CNT_W-1:0]   rx_count;
        logic [TIMER_W-1:0] rx_timer;
        logic               rx_active;
        result_t            due_pins[$];
        int unsigned        mismatches;

        function new();
            bit_period = BIT_PERIOD_RESET;
            half_bit   = HALF_BIT_RESET;
            tx_shift   = '0;
            tx_count   = '0;
            tx_timer   = '0;
            tx_active  = 1'b0;
            tx_level   = 1'b1;
            rx_shift   = '0;
            rx_count   = '0;
            rx_timer   = '0;
            rx_active  = 1'b0;
            mismatches = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [7:0] val);
            case (idx)
                REG_BIT_PERIOD: bit_period = val;
                REG_HALF_BIT:   half_bit = val;
                default: ;
            endcase
        endfunction

        // one tick on a bit timer; true when the bit ends and the timer restarts
        function bit bit_ends(inout logic [TIMER_W-1:0] timer, input logic [7:0] limit);
            if (timer >= limit)
            begin
                timer = '0;
                return 1'b1;
            end
            timer = timer + 1'b1;
            return 1'b0;
        endfunction

        function void take_word(logic [IN_TDATA_W-1:0] w);
            logic       tick;
            logic       line;
            logic       start;
            logic [7:0] data_v;
            result_t    r;
            tick   = w[0];
            line   = w[1];
            start  = w[2];
            data_v = w[10:3];
            r      = '0;

            if (!tx_active)
            begin
                if (start)
                begin
                    tx_shift  = SHIFT_W'(data_v);
                    tx_count  = '0;
                    tx_timer  = '0;
                    tx_active = 1'b1;
                    tx_level  = 1'b0;
                end
            end
            else if (tick)
            begin
                if (bit_ends(tx_timer, bit_period))
                begin
                    tx_count = tx_count + 1'b1;
                    if (tx_count >= 1 && tx_count <= DATA_BITS)
                    begin
                        tx_level = tx_shift[0];
                        tx_shift = tx_shift >> 1;
                    end
                    else if (tx_count == DATA_BITS + 1)
                    begin
                        tx_level = 1'b1;
                    end
                    else
                    begin
                        tx_level  = 1'b1;
                        tx_active = 1'b0;
                    end
                end
            end

            if (!rx_active)
            begin
                if (!line)
                begin
                    rx_active = 1'b1;
                    rx_count  = '0;
                    rx_timer  = '0;
                    rx_shift  = '0;
                end
            end
            else if (tick)
            begin
                if (bit_ends(rx_timer, (rx_count == 0) ? half_bit : bit_period))
                begin
                    if (rx_count == 0)
                    begin
                        if (line)
                        begin
                            r.rx_done   = 1'b1;
                            r.rx_byte   = RX_ERROR_BYTE;
                            r.rx_status = RX_FALSE_START;
                            rx_active   = 1'b0;
                        end
                        else
                        begin
                            rx_count = CNT_W'(1);
                        end
                    end
                    else if (rx_count <= DATA_BITS)
                    begin
                        if (line)
                            rx_shift[rx_count - 1] = 1'b1;
                        rx_count = rx_count + 1'b1;
                    end
                    else
                    begin
                        r.rx_done = 1'b1;
                        if (line)
                        begin
                            r.rx_byte   = rx_shift[7:0];
                            r.rx_status = RX_OK;
                        end
                        else
                        begin
                            r.rx_byte   = RX_ERROR_BYTE;
                            r.rx_status = RX_STOP_LOW;
                        end
                        rx_active = 1'b0;
                    end
                end
            end

            r.tx_line = tx_level;
            r.tx_busy = tx_active;
            due_pins.push_back(r);
        endfunction

        function void match_result(logic [OUT_TDATA_W-1:0] w);
            result_t got;
            result_t want;
            got = w[$bits(result_t)-1:0];
            if (due_pins.size() == 0)
            begin
                $error("result word %h with nothing pending", w);
                mismatches++;
                return;
            end
            want = due_pins.pop_front();
            if (got.tx_line !== want.tx_line)
            begin
                $error("tx_line: expected %0h, got %0h", want.tx_line, got.tx_line);
                mismatches++;
            end
            if (got.tx_busy !== want.tx_busy)
            begin
                $error("tx_busy: expected %0h, got %0h", want.tx_busy, got.tx_busy);
                mismatches++;
            end
            if (got.rx_done !== want.rx_done)
            begin
                $error("rx_done: expected %0h, got %0h", want.rx_done, got.rx_done);
                mismatches++;
            end
            if (got.rx_byte !== want.rx_byte)
            begin
                $error("rx_byte: expected %0h, got %0h", want.rx_byte, got.rx_byte);
                mismatches++;
            end
            if (got.rx_status !== want.rx_status)
            begin
                $error("rx_status: expected %0h, got %0h", want.rx_status, got.rx_status);
                mismatches++;
            end
            if (w[OUT_TDATA_W-1:$bits(result_t)] !== '0)
            begin
                $error("pad: expected 0, got %0h", w[OUT_TDATA_W-1:$bits(result_t)]);
                mismatches++;
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = REG_BIT_PERIOD;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    uart_frame_tracker board = new();

    bit          calm = 1'b0;
    bit          hold_req = 1'b0;
    int unsigned cycles = 0;
    int          cur_bp = BIT_PERIOD_RESET;
    int          cur_hb = HALF_BIT_RESET;
    line_mode_t  line_mode = LINE_LOOP;
    logic        plan_level[$];
    int          plan_ticks[$];

    uart_8n1_transceiver uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("uart_8n1_transceiver regression: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                board.take_word(s_tdata);
            if (m_tvalid && m_tready)
                board.match_result(m_tdata);
        end
    end

    // output side: random stalls, plus one long hold-off on request
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_tready = 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            m_tready = calm ? 1'b1 : ($urandom_range(99) >= 26);
        end
    end

    task automatic write_reg(input cfg_reg_t idx, input logic [7:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge clk); while (!cfg_ready);
        board.set_reg(idx, val);
        if (idx == REG_BIT_PERIOD)
            cur_bp = val;
        else
            cur_hb = val;
        @(negedge clk);
    endtask

    // stop sending, wait for the output side to catch up, then load both timing registers
    task automatic load_timing(input logic [7:0] bp, input logic [7:0] hb);
        s_tvalid = 1'b0;
        while (board.due_pins.size() != 0) @(posedge clk);
        repeat (2) @(negedge clk);
        if ($urandom_range(1))
        begin
            write_reg(REG_HALF_BIT, hb);
            write_reg(REG_BIT_PERIOD, bp);
        end
        else
        begin
            write_reg(REG_BIT_PERIOD, bp);
            write_reg(REG_HALF_BIT, hb);
        end
        cfg_valid = 1'b0;
    endtask

    task automatic send_word(input logic tick, input logic line, input logic start,
                             input logic [7:0] data);
        while (!calm && $urandom_range(99) < 26)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {{(IN_TDATA_W-11){1'b0}}, data, start, line, tick};
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
    endtask

    // idle gap, then a glitch, a clean frame or a frame with its stop bit low
    function automatic void queue_frame();
        int         per_bit;
        int         kind;
        logic [7:0] d;
        per_bit = cur_bp + 1;
        kind    = $urandom_range(99);
        d       = 8'($urandom_range(255));
        plan_level.push_back(1'b1);
        plan_ticks.push_back($urandom_range(1, 2 * per_bit));
        if (kind < 10)
        begin
            plan_level.push_back(1'b0);
            plan_ticks.push_back(1);
        end
        else
        begin
            plan_level.push_back(1'b0);
            plan_ticks.push_back(per_bit);
            for (int i = 0; i < DATA_BITS; i++)
            begin
                plan_level.push_back(d[i]);
                plan_ticks.push_back(per_bit);
            end
            plan_level.push_back(kind >= 20);
            plan_ticks.push_back(per_bit);
        end
    endfunction

    function automatic logic pick_line(input logic tick);
        logic line;
        case (line_mode)
            LINE_LOOP: line = board.tx_level;
            LINE_NOISE: line = 1'($urandom_range(1));
            default:
            begin
                if (plan_level.size() == 0)
                    queue_frame();
                line = plan_level[0];
                if (tick)
                begin
                    plan_ticks[0]--;
                    if (plan_ticks[0] <= 0)
                    begin
                        void'(plan_level.pop_front());
                        void'(plan_ticks.pop_front());
                    end
                end
            end
        endcase
        return line;
    endfunction

    task automatic run_words(input int count, input int tick_pct);
        int         r;
        logic       tick;
        logic       line;
        logic       start;
        logic [7:0] data;
        for (int n = 0; n < count; n++)
        begin
            if (n % 30 == 0)
            begin
                r = $urandom_range(99);
                line_mode = (r < 55) ? LINE_LOOP : (r < 85) ? LINE_FRAMES : LINE_NOISE;
                plan_level.delete();
                plan_ticks.delete();
            end
            tick  = ($urandom_range(99) < tick_pct);
            start = ($urandom_range(99) < 25);
            data  = 8'($urandom_range(255));
            line  = pick_line(tick);
            send_word(tick, line, start, data);
        end
    endtask

    initial
    begin
        int         bp;
        int         hb;
        int         tick_pct;
        logic [7:0] bp_fixed [6];
        logic [7:0] hb_fixed [6];
        bp_fixed = '{8'd1, 8'd3, 8'd2, 8'd7, 8'd255, 8'd1};
        hb_fixed = '{8'd0, 8'd1, 8'd255, 8'd3, 8'd255, 8'd1};

        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: shortest timing, so every tick ends a start check and every other tick ends a bit
        load_timing(8'd1, 8'd0);
        send_word(1'b1, 1'b1, 1'b1, 8'hFF);  // tx start, tick on the same clock not counted
        send_word(1'b1, 1'b1, 1'b1, 8'h00);  // request while busy
        send_word(1'b1, 1'b0, 1'b0, 8'h00);  // rx start edge on a tick
        send_word(1'b1, 1'b1, 1'b0, 8'h00);  // line back high at the check: false start
        send_word(1'b0, 1'b0, 1'b0, 8'hA5);  // new edge right after the reception
        send_word(1'b1, 1'b0, 1'b0, 8'hA5);  // start confirmed
        for (int i = 0; i < 18; i++)
            send_word(1'b1, (i < 16) ? i[1] : 1'b0, 1'b1, 8'h5A);  // ends with stop low

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p < 6)
            begin
                bp = bp_fixed[p];
                hb = hb_fixed[p];
            end
            else
            begin
                bp = $urandom_range(1, 6);
                hb = $urandom_range(0, bp);
            end
            load_timing(8'(bp), 8'(hb));
            tick_pct = (p == 4 || p % 3 != 0) ? 100 : 50;
            calm = (p == 5);
            if (p == 3)
                hold_req = 1'b1;
            run_words(PHASE_WORDS, tick_pct);
        end
        calm = 1'b0;
        s_tvalid = 1'b0;

        while (board.due_pins.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        if (board.mismatches == 0)
            $display("uart_8n1_transceiver regression: pass");
        else
            $display("uart_8n1_transceiver regression: fail");
        $finish;
    end

endmodule

@@ uart_8n1_transceiver.f @@
design/uart_pkg.sv
design/uart_8n1_transceiver.sv
design/uart_checker.sv
sim/tb.sv
